// ----- rtl/core/arcss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcss_pkg
// Types, microcode and coefficient helpers shared by the arcsin series block.
// ----------------------------------------------------------------------------
package arcss_pkg;

   localparam int X_W     = 31;   // argument width, signed Q1.FRAC
   localparam int IDX_W   = 6;    // term count and term index width
   localparam int SUM_W   = 32;   // partial sum width
   localparam int COEF_W  = 14;   // holds (2i-1)^2 and 2i(2i+1) for any 6-bit index
   localparam int PC_W    = 4;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_SQUARE,
      OP_X2,
      OP_MUL_MAG,
      OP_MUL_COEF,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_ACC
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_NO_REQ,
      COND_DIV_BUSY,
      COND_DONE,
      COND_MORE,
      COND_ALWAYS
   } cond_type;

   typedef struct packed {
      op_type               op;
      cond_type             cond;
      logic                 emit;
      logic [PC_W-1:0]      target;
   } ctrl_word_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
   localparam logic [PC_W-1:0] PC_TERM = 4'd3;
   localparam logic [PC_W-1:0] PC_DIV  = 4'd6;

   // microcode program, one control word per step
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, emit: 1'b0, target: PC_IDLE};
      unique case (pc)
         4'd0: w = '{op: OP_LOAD,     cond: COND_NO_REQ,   emit: 1'b0, target: PC_IDLE};
         4'd1: w = '{op: OP_SQUARE,   cond: COND_NEXT,     emit: 1'b0, target: PC_IDLE};
         4'd2: w = '{op: OP_X2,       cond: COND_DONE,     emit: 1'b1, target: PC_IDLE};
         4'd3: w = '{op: OP_MUL_MAG,  cond: COND_NEXT,     emit: 1'b0, target: PC_IDLE};
         4'd4: w = '{op: OP_MUL_COEF, cond: COND_NEXT,     emit: 1'b0, target: PC_IDLE};
         4'd5: w = '{op: OP_DIV_LOAD, cond: COND_NEXT,     emit: 1'b0, target: PC_IDLE};
         4'd6: w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, emit: 1'b0, target: PC_DIV};
         4'd7: w = '{op: OP_ACC,      cond: COND_NEXT,     emit: 1'b0, target: PC_IDLE};
         4'd8: w = '{op: OP_NOP,      cond: COND_MORE,     emit: 1'b1, target: PC_TERM};
         default: w = '{op: OP_NOP,   cond: COND_ALWAYS,   emit: 1'b0, target: PC_IDLE};
      endcase
      return w;
   endfunction

   // (2i-1)^2
   function automatic logic [COEF_W-1:0] coef_num(input logic [IDX_W-1:0] i);
      logic [COEF_W-1:0] t;
      t = COEF_W'({i, 1'b0}) - COEF_W'(1);
      return COEF_W'(t * t);
   endfunction

   // 2i(2i+1)
   function automatic logic [COEF_W-1:0] coef_den(input logic [IDX_W-1:0] i);
      logic [COEF_W-1:0] t;
      t = COEF_W'({i, 1'b0});
      return COEF_W'(t * (t + COEF_W'(1)));
   endfunction

endpackage

// ----- rtl/core/arcsin_series_partial_sums.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcsin_series_partial_sums
// Maclaurin partial sums of arcsin(x), x signed Q1.FRAC_BITS, sums signed Q2.FRAC_BITS,
// run by a microcoded sequencer over one multiplier path and a radix-4 divider.
// ----------------------------------------------------------------------------
//  channel | dir | fields (low bit up)                          | per item
//  req_    | in  | tdata: x_value[30:0], term_count[36:31]      | one transfer
//  rsp_    | out | tdata: partial_sum[31:0], term_index[37:32]  | 1 + n transfers
//          |     | tlast: last partial sum of the item          |
//
// n is clipped to MAX_TERMS; each term is two multiplies, a divide and one
// accumulate, all through the single datapath stepped by the microcode.
// a new item is taken only at the idle step of the program.
// a held result stalls the program at its emit step; the output register lets
// the sequencer keep working while the previous result waits.
// synchronous reset returns the program counter to idle and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module arcsin_series_partial_sums #(
   parameter int MAX_TERMS = 32,
   parameter int FRAC_BITS = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // x_value[30:0], term_count[36:31], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // partial_sum[31:0], term_index[37:32], zero pad
   output logic        rsp_tlast
);
   import arcss_pkg::*;

   localparam int PROD_W = 2 * X_W;
   localparam int MCO_W  = X_W + COEF_W;
   localparam int DVD_W  = MCO_W + (MCO_W % 2);
   localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_TERMS);

   ctrl_word_type     ctrl;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic              adv;
   logic              done;

   logic              neg_ff, neg_in;
   logic [X_W-1:0]    ax_ff, ax_in;
   logic [X_W-1:0]    x2_ff, x2_in;
   logic [X_W-1:0]    mag_ff, mag_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  n_ff, n_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [X_W-1:0]    req_x;
   logic [IDX_W-1:0]  req_n;
   logic [X_W-1:0]    m_val;
   logic [COEF_W-1:0] num, den;
   div_ctrl_type      div_ctrl;
   logic [DVD_W-1:0]  div_quo;
   logic              div_last;
   logic [X_W-1:0]    q_val;
   logic signed [SUM_W:0] sum_wide;

   assign ctrl  = ucode(pc_ff);
   assign done  = (idx_ff == n_ff);
   // an emit step waits while the output register is full and rsp_tready is low
   assign adv   = !(ctrl.emit && rsp_valid_ff && !rsp_tready);

   assign req_x = req_tdata[X_W-1:0];
   assign req_n = req_tdata[X_W +: IDX_W];
   assign m_val = prod_ff[FRAC_BITS +: X_W];
   assign num   = coef_num(idx_ff);
   assign den   = coef_den(idx_ff);
   assign q_val = div_quo[X_W-1:0];

   assign req_tready = (ctrl.op == OP_LOAD);

   assign div_ctrl.load = (ctrl.op == OP_DIV_LOAD);
   assign div_ctrl.step = (ctrl.op == OP_DIV_STEP);

   arcss_div #(
      .DVD_W (DVD_W),
      .DIV_W (COEF_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (prod_ff[DVD_W-1:0]),
      .divisor   (den),
      .quotient  (div_quo),
      .last_step (div_last)
   );

   // program counter
   always_comb begin
      pc_in = pc_ff;
      if (adv) begin
         unique case (ctrl.cond)
            COND_NEXT:     pc_in = pc_ff + PC_W'(1);
            COND_NO_REQ:   pc_in = req_tvalid ? pc_ff + PC_W'(1) : ctrl.target;
            COND_DIV_BUSY: pc_in = div_last ? pc_ff + PC_W'(1) : ctrl.target;
            COND_DONE:     pc_in = done ? ctrl.target : pc_ff + PC_W'(1);
            COND_MORE:     pc_in = done ? pc_ff + PC_W'(1) : ctrl.target;
            COND_ALWAYS:   pc_in = ctrl.target;
            default:       pc_in = PC_IDLE;
         endcase
      end
   end

   // signed add or subtract of the new term by the sign of x; clipped to 32 bits at accumulate
   always_comb begin
      if (neg_ff) begin
         sum_wide = {sum_ff[SUM_W-1], sum_ff} - $signed({2'b00, q_val});
      end else begin
         sum_wide = {sum_ff[SUM_W-1], sum_ff} + $signed({2'b00, q_val});
      end
   end

   // datapath
   always_comb begin
      neg_in  = neg_ff;
      ax_in   = ax_ff;
      x2_in   = x2_ff;
      mag_in  = mag_ff;
      prod_in = prod_ff;
      sum_in  = sum_ff;
      idx_in  = idx_ff;
      n_in    = n_ff;
      if (adv) begin
         unique case (ctrl.op)
            OP_LOAD: begin
               if (req_tvalid) begin
                  neg_in = req_x[X_W-1];
                  ax_in  = req_x[X_W-1] ? X_W'(~req_x + X_W'(1)) : req_x;
                  mag_in = req_x[X_W-1] ? X_W'(~req_x + X_W'(1)) : req_x;
                  sum_in = {req_x[X_W-1], req_x};
                  idx_in = '0;
                  n_in   = (req_n > MAX_N) ? MAX_N : req_n;
               end
            end
            OP_SQUARE:   prod_in = PROD_W'(ax_ff * ax_ff);
            OP_X2:       x2_in = prod_ff[FRAC_BITS +: X_W];
            OP_MUL_MAG: begin
               prod_in = PROD_W'(mag_ff * x2_ff);
               idx_in  = idx_ff + IDX_W'(1);
            end
            OP_MUL_COEF: prod_in = PROD_W'(m_val * num);
            OP_ACC: begin
               mag_in = q_val;
               if (sum_wide > $signed({1'b0, {(SUM_W-1){1'b1}}})) begin
                  sum_in = {1'b0, {(SUM_W-1){1'b1}}};
               end else if (sum_wide < $signed({2'b11, {(SUM_W-1){1'b0}}})) begin
                  sum_in = {1'b1, {(SUM_W-1){1'b0}}};
               end else begin
                  sum_in = sum_wide[SUM_W-1:0];
               end
            end
            OP_NOP, OP_DIV_LOAD, OP_DIV_STEP: begin
            end
            default: begin
            end
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctrl.emit && adv) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = sum_ff;
         rsp_idx_in   = idx_ff;
         rsp_last_in  = done;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      ax_ff       <= ax_in;
      x2_ff       <= x2_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_idx_ff, rsp_sum_ff};
   assign rsp_tlast  = rsp_last_ff;

   // inputs are taken only at the idle step
   a_load_at_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (pc_ff == PC_IDLE))
      else $error("input taken outside the idle step");

   // accumulate follows the final divider step
   a_acc_after_div: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_ACC) |-> ($past(ctrl.op) == OP_DIV_STEP) && $past(div_last))
      else $error("accumulate before divide finished");

   // a term never grows, so the quotient fits the magnitude width
   a_quo_fits: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_ACC) |-> (div_quo[DVD_W-1:X_W] == '0))
      else $error("quotient overflow");

   // term index stays within the clipped count while an item is in work
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff != PC_IDLE) |-> (idx_ff <= n_ff))
      else $error("term index past term count");

endmodule

// ----- rtl/core/arcss_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcss_div
// Restoring unsigned divider, two quotient bits per cycle while step is held, truncating.
// ----------------------------------------------------------------------------
module arcss_div #(
   parameter int DVD_W = 46,
   parameter int DIV_W = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  arcss_pkg::div_ctrl_type    ctrl,
   input  logic [DVD_W-1:0]           dividend,
   input  logic [DIV_W-1:0]           divisor,
   output logic [DVD_W-1:0]           quotient,
   output logic                       last_step
);
   import arcss_pkg::*;

   localparam int STEPS = DVD_W / 2;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] r;
   logic [DVD_W-1:0] d;
   logic [DIV_W:0]   trial;

   // two dependent restoring steps, quotient bits shift in at the bottom
   always_comb begin
      r = rem_ff;
      d = dvd_ff;
      trial = '0;
      for (int k = 0; k < 2; k++) begin
         trial = {r, d[DVD_W-1]};
         d = {d[DVD_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            r = DIV_W'(trial - {1'b0, divisor});
            d[0] = 1'b1;
         end else begin
            r = trial[DIV_W-1:0];
         end
      end
   end

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = '0;
      end else if (ctrl.step) begin
         dvd_in = d;
         rem_in = r;
         cnt_in = (cnt_ff == CNT_LAST) ? cnt_ff : cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign quotient  = dvd_ff;
   assign last_step = (cnt_ff == CNT_LAST);

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for arcsin_series_partial_sums: a directed table of
// arguments and term counts, then random items under random stalls on both
// streams; each partial sum is checked against a table value or series model.
// ----------------------------------------------------------------------------
module tb;
   import arcss_pkg::*;

   localparam int     MAX_TERMS   = 32;
   localparam int     FRAC_BITS   = 30;
   localparam int     RSP_HOLD    = 700;    // long receiver hold-off, in cycles
   localparam int     QUIET_LIMIT = 4000;   // cycles with no transfer at all
   localparam int     DRAIN       = 40;
   localparam int     REPORT_MAX  = 10;
   localparam longint SUM_MAX     = 64'sd2147483647;
   localparam longint SUM_MIN     = -64'sd2147483648;

   localparam logic [X_W-1:0] X_MAX     = 31'h3FFF_FFFF;  // just below +1.0
   localparam logic [X_W-1:0] X_NEG_ONE = 31'h4000_0000;  // exactly -1.0
   localparam logic [X_W-1:0] X_MIN     = 31'h4000_0001;  // just above -1.0
   localparam logic [X_W-1:0] X_HALF    = 31'h2000_0000;
   localparam logic [X_W-1:0] X_NHALF   = 31'h6000_0000;
   localparam logic [X_W-1:0] X_ULP     = 31'h0000_0001;
   localparam logic [X_W-1:0] X_NULP    = 31'h7FFF_FFFF;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [IDX_W-1:0]        idx;
      logic                    last;
   } psum_type;

   typedef struct packed {
      logic [X_W-1:0]          x;
      logic [IDX_W-1:0]        n;
      logic                    fixed;      // every partial sum equals fixed_sum
      logic signed [SUM_W-1:0] fixed_sum;
   } dir_row_type;

   localparam int N_DIR = 24;

   //                 x            n      fixed  fixed_sum
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{31'h0,        6'd0,  1'b1, 32'h0000_0000},
      '{31'h0,        6'd32, 1'b1, 32'h0000_0000},
      '{31'h0,        6'd63, 1'b1, 32'h0000_0000},
      '{X_MAX,        6'd0,  1'b1, 32'h3FFF_FFFF},
      '{X_NEG_ONE,    6'd0,  1'b1, 32'hC000_0000},
      '{X_NULP,       6'd0,  1'b1, 32'hFFFF_FFFF},
      '{X_MAX,        6'd1,  1'b0, 32'h0},
      '{X_MAX,        6'd32, 1'b0, 32'h0},
      '{X_NEG_ONE,    6'd32, 1'b0, 32'h0},
      '{X_MIN,        6'd32, 1'b0, 32'h0},
      '{X_MAX,        6'd63, 1'b0, 32'h0},
      '{X_NEG_ONE,    6'd63, 1'b0, 32'h0},
      '{X_HALF,       6'd1,  1'b0, 32'h0},
      '{X_HALF,       6'd2,  1'b0, 32'h0},
      '{X_HALF,       6'd5,  1'b0, 32'h0},
      '{X_NHALF,      6'd10, 1'b0, 32'h0},
      '{X_ULP,        6'd32, 1'b0, 32'h0},
      '{X_NULP,       6'd3,  1'b0, 32'h0},
      '{31'h2AAA_AAAA, 6'd21, 1'b0, 32'h0},
      '{31'h5555_5555, 6'd33, 1'b0, 32'h0},
      '{31'h1234_5678, 6'd40, 1'b0, 32'h0},
      '{31'h6DB6_DB6D, 6'd48, 1'b0, 32'h0},
      '{31'h0000_8000, 6'd7,  1'b0, 32'h0},
      '{31'h3000_0000, 6'd16, 1'b0, 32'h0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // x_value[30:0], term_count[36:31], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // partial_sum[31:0], term_index[37:32], zero pad
   logic        rsp_tlast;

   psum_type arcsin_sums_due[$];
   int    mismatches = 0;
   int    quiet_cycles = 0;
   bit    idle_on = 1'b1;
   bit    hold_rsp = 1'b0;

   arcsin_series_partial_sums #(
      .MAX_TERMS(MAX_TERMS),
      .FRAC_BITS(FRAC_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int clip_terms(input logic [IDX_W-1:0] cnt);
      return (int'(cnt) > MAX_TERMS) ? MAX_TERMS : int'(cnt);
   endfunction

   // series on magnitudes, sign of x applied to each term, sum saturated
   function automatic void forecast_arcsin_sums(input logic [X_W-1:0] xv,
                                                input logic [IDX_W-1:0] cnt);
      longint x, ax, x2, mag, m, num, den, s;
      int     nt;
      bit     neg;
      psum_type e;
      x   = longint'($signed(xv));
      neg = (x < 0);
      ax  = neg ? -x : x;
      x2  = (ax * ax) >> FRAC_BITS;
      nt  = clip_terms(cnt);
      mag = ax;
      s   = x;
      e = '{sum: SUM_W'(s), idx: '0, last: (nt == 0)};
      arcsin_sums_due.push_back(e);
      for (int i = 1; i <= nt; i++) begin
         num = longint'((2 * i - 1) * (2 * i - 1));
         den = longint'((2 * i) * (2 * i + 1));
         m   = (mag * x2) >> FRAC_BITS;
         mag = (m * num) / den;
         s   = neg ? s - mag : s + mag;
         if (s > SUM_MAX) s = SUM_MAX;
         if (s < SUM_MIN) s = SUM_MIN;
         e = '{sum: SUM_W'(s), idx: IDX_W'(i), last: (i == nt)};
         arcsin_sums_due.push_back(e);
      end
   endfunction

   function automatic int stall_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [X_W-1:0] random_arg();
      int             r;
      logic [X_W-1:0] mag;
      r = $urandom_range(0, 9);
      if (r < 5) return X_W'($urandom);
      if (r < 7) mag = X_MAX - X_W'($urandom_range(0, 1 << 20));
      else if (r < 9) mag = X_W'($urandom_range(0, 1 << 16));
      else mag = X_W'($urandom_range(0, 1));
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // mostly short series; a few at or past the term limit
   function automatic logic [IDX_W-1:0] random_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)  return '0;
      if (r < 70) return IDX_W'($urandom_range(1, 6));
      if (r < 90) return IDX_W'($urandom_range(7, 20));
      if (r < 96) return IDX_W'($urandom_range(21, 32));
      return IDX_W'($urandom_range(33, 63));
   endfunction

   // entered and left at a falling edge
   task automatic offer_item(input logic [X_W-1:0] xv, input logic [IDX_W-1:0] cnt,
                             input logic fixed, input logic signed [SUM_W-1:0] fixed_sum);
      int    gap;
      int    nt;
      psum_type e;
      gap = idle_on ? stall_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, cnt, xv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (fixed) begin
         nt = clip_terms(cnt);
         for (int i = 0; i <= nt; i++) begin
            e = '{sum: fixed_sum, idx: IDX_W'(i), last: (i == nt)};
            arcsin_sums_due.push_back(e);
         end
      end else begin
         forecast_arcsin_sums(xv, cnt);
      end
      @(negedge clock);
   endtask

   task automatic offer_random(input int count);
      for (int k = 0; k < count; k++)
         offer_item(random_arg(), random_count(), 1'b0, '0);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            stall_left = RSP_HOLD;
            hold_rsp   = 1'b0;
         end else if (stall_left == 0 && rsp_tready && idle_on) begin
            stall_left = stall_gap();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      psum_type want;
      psum_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{sum: rsp_tdata[31:0], idx: rsp_tdata[37:32], last: rsp_tlast};
         if (arcsin_sums_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected transfer: sum %0d idx %0d last %0b",
                        got.sum, got.idx, got.last);
         end else begin
            want = arcsin_sums_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"mismatch: expected sum %0d idx %0d last %0b, ",
                            "got sum %0d idx %0d last %0b"},
                           want.sum, want.idx, want.last, got.sum, got.idx, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < N_DIR; r++)
         offer_item(DIR_ROWS[r].x, DIR_ROWS[r].n, DIR_ROWS[r].fixed, DIR_ROWS[r].fixed_sum);

      offer_random(140);

      // sender pauses until the block has drained
      req_tvalid <= 1'b0;
      do @(negedge clock); while (arcsin_sums_due.size() != 0);

      // receiver holds off while the sender keeps offering back to back
      idle_on  = 1'b0;
      hold_rsp = 1'b1;
      offer_random(10);
      offer_random(90);

      idle_on = 1'b1;
      offer_random(60);
      req_tvalid <= 1'b0;

      while (arcsin_sums_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0 && arcsin_sums_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
